/* rtl/core/btmm_pkg.sv */
// Shared constants, codes and types of the battery trimmed-mean monitor.
package btmm_pkg;

    localparam int RING_DEPTH_DEF   = 7;
    localparam int SAMPLE_WIDTH_DEF = 10;

    localparam int VOLT_W      = 15;
    localparam int LEVEL_W     = 7;
    localparam int REF_W       = 12;
    localparam int PERIOD_W    = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int STEP_W      = 9;

    localparam logic [VOLT_W-1:0]   VOLT_MAX    = 15'h7FFF;
    localparam logic [REF_W-1:0]    REF_RESET   = 12'd1200;
    localparam logic [PERIOD_W-1:0] FAST_RESET  = 8'd1;
    localparam logic [PERIOD_W-1:0] SLOW_RESET  = 8'd10;
    localparam int                  SCALE_SHIFT = 11;

    localparam logic [VOLT_W-1:0] LVL_FULL_MV = 15'd4200;
    localparam logic [VOLT_W-1:0] LVL_HIGH_MV = 15'd4000;
    localparam logic [VOLT_W-1:0] LVL_MID_MV  = 15'd3600;
    localparam logic [VOLT_W-1:0] LVL_LOW_MV  = 15'd3200;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH_BASE = 7'd90;
    localparam logic [LEVEL_W-1:0] LEVEL_MID_BASE  = 7'd10;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW_BASE  = 7'd0;

    // steps of 20 mV and 40 mV are a shift followed by the divide by five
    localparam int HIGH_STEP_SHIFT = 2;
    localparam int LOW_STEP_SHIFT  = 3;

    // exact x/5 for x < 512: (x * 820) >> 12
    localparam int               DIV5_RECIP_W = 10;
    localparam logic [DIV5_RECIP_W-1:0] DIV5_RECIP = 10'd820;
    localparam int               DIV5_SHIFT   = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REFERENCE_MV = 2'd0,
        CFG_FAST_PERIOD  = 2'd1,
        CFG_SLOW_PERIOD  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic               done;
        logic [VOLT_W-1:0]  volt;
        logic [LEVEL_W-1:0] level;
    } calc_res_t;

endpackage

/* rtl/core/btmm_if.sv */
// Valid/ready channel interfaces for input items and result items.
interface btmm_item_if
    import btmm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    charge_full;

    modport source (output valid, output operation, output sample, output charge_full,
                    input ready);
    modport sink   (input valid, input operation, input sample, input charge_full,
                    output ready);
endinterface

interface btmm_result_if
    import btmm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               start_conversion;
    logic [VOLT_W-1:0]  voltage_mv;
    logic [LEVEL_W-1:0] level_pct;
    logic               level_changed;

    modport source (output valid, output start_conversion, output voltage_mv,
                    output level_pct, output level_changed, input ready);
    modport sink   (input valid, input start_conversion, input voltage_mv,
                    input level_pct, input level_changed, output ready);
endinterface

/* rtl/core/battery_trimmed_mean_monitor_core.sv */
// Battery monitor: a tick goes from acceptance through the emit state, which waits until
// the output register is free, and back to idle; a sample is handled by the scan of the
// ring memory through its single read port, one entry per cycle,
// followed by the five-stage mean, scaling and level pipeline. The ring reads as
// zero after reset until each entry is written, with no clearing pass. One result is
// given per item; a finished result waits in an output register, so the next item
// is taken while the previous result is still unread.
module battery_trimmed_mean_monitor_core
    import btmm_pkg::*;
#(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    btmm_item_if.sink              item,
    btmm_result_if.source          result
);
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(RING_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [REF_W-1:0]     ref_reg;
    logic [PERIOD_W-1:0]  fast_reg;
    logic [PERIOD_W-1:0]  slow_reg;
    logic [PERIOD_W-1:0]  tick_reg;
    logic                 slow_sel_reg;
    logic [VOLT_W-1:0]    last_volt_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic                 full_reg;
    logic                 stg_start_reg;
    logic                 stg_changed_reg;
    logic                 out_valid_reg;
    logic                 out_start_reg;
    logic [VOLT_W-1:0]    out_volt_reg;
    logic [LEVEL_W-1:0]   out_level_reg;
    logic                 out_changed_reg;

    logic                 accept;
    logic                 sample_wr;
    logic                 out_load;
    logic [PERIOD_W-1:0]  period;
    logic [PERIOD_W-1:0]  tick_inc;
    logic                 tick_hit;
    logic                 ring_done;
    logic [SUM_W-1:0]     trimmed;
    calc_res_t            calc_res;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign sample_wr  = accept && item.operation;
    assign out_load   = (state_reg == S_EMIT) && (!out_valid_reg || result.ready);

    assign period   = slow_sel_reg ? slow_reg : fast_reg;
    assign tick_inc = tick_reg + 1'b1;
    assign tick_hit = (tick_inc >= period);

    btmm_ring #(
        .RING_DEPTH   (RING_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sample_wr),
        .wr_data (item.sample),
        .done    (ring_done),
        .trimmed (trimmed)
    );

    btmm_calc #(
        .RING_DEPTH   (RING_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_calc (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ring_done),
        .trimmed (trimmed),
        .ref_mv  (ref_reg),
        .full    (full_reg),
        .res     (calc_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = item.operation ? S_BUSY : S_EMIT;
                end
            end
            S_BUSY:
            begin
                if (calc_res.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ref_reg         <= REF_RESET;
            fast_reg        <= FAST_RESET;
            slow_reg        <= SLOW_RESET;
            tick_reg        <= '0;
            slow_sel_reg    <= 1'b0;
            last_volt_reg   <= '0;
            level_reg       <= '0;
            full_reg        <= 1'b0;
            stg_start_reg   <= 1'b0;
            stg_changed_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_REFERENCE_MV: ref_reg  <= cfg_data[REF_W-1:0];
                    CFG_FAST_PERIOD:  fast_reg <= cfg_data[PERIOD_W-1:0];
                    CFG_SLOW_PERIOD:  slow_reg <= cfg_data[PERIOD_W-1:0];
                    default:          ;
                endcase
            end
            if (accept)
            begin
                stg_changed_reg <= 1'b0;
                if (item.operation)
                begin
                    full_reg      <= item.charge_full;
                    stg_start_reg <= 1'b0;
                end
                else
                begin
                    tick_reg      <= tick_hit ? '0 : tick_inc;
                    stg_start_reg <= tick_hit;
                end
            end
            if ((state_reg == S_BUSY) && calc_res.done)
            begin
                if ((calc_res.volt == last_volt_reg) && (last_volt_reg != '0))
                begin
                    slow_sel_reg <= 1'b1;
                end
                last_volt_reg   <= calc_res.volt;
                level_reg       <= calc_res.level;
                stg_changed_reg <= (calc_res.level != level_reg);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_start_reg   <= stg_start_reg;
            out_volt_reg    <= last_volt_reg;
            out_level_reg   <= level_reg;
            out_changed_reg <= stg_changed_reg;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.start_conversion = out_start_reg;
    assign result.voltage_mv       = out_volt_reg;
    assign result.level_pct        = out_level_reg;
    assign result.level_changed    = out_changed_reg;
endmodule

/* rtl/core/btmm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module btmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/core/btmm_ring.sv */
// Sample ring: stores samples in RAM and scans it for sum, largest and smallest entry, giving the trimmed sum.
module btmm_ring
    import btmm_pkg::*;
#(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int AW    = $clog2(RING_DEPTH),
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(RING_DEPTH)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [SAMPLE_WIDTH-1:0] wr_data,
    output logic                    done,
    output logic [SUM_W-1:0]        trimmed
);
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

    logic [AW-1:0]           slot_reg;
    logic [AW-1:0]           slot_next;
    logic [RING_DEPTH-1:0]   valid_reg;
    logic                    scan_reg;
    logic [AW-1:0]           rd_addr_reg;
    logic                    dvld_reg;
    logic [AW-1:0]           daddr_reg;
    logic                    dlast_reg;
    logic                    fin_reg;
    logic                    done_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SAMPLE_WIDTH-1:0] hi_reg;
    logic [SAMPLE_WIDTH-1:0] lo_reg;
    logic [SUM_W-1:0]        trimmed_reg;
    logic [SAMPLE_WIDTH-1:0] rdata;
    logic [SAMPLE_WIDTH-1:0] entry;

    btmm_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (slot_reg),
        .wdata (wr_data),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    assign slot_next = (slot_reg == LAST_ADDR) ? '0 : slot_reg + 1'b1;
    // never-written entries are read as zero
    assign entry     = valid_reg[daddr_reg] ? rdata : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            valid_reg   <= '0;
            scan_reg    <= 1'b0;
            rd_addr_reg <= '0;
            dvld_reg    <= 1'b0;
            dlast_reg   <= 1'b0;
            fin_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            dvld_reg  <= scan_reg;
            dlast_reg <= scan_reg && (rd_addr_reg == LAST_ADDR);
            fin_reg   <= dvld_reg && dlast_reg;
            done_reg  <= fin_reg;
            if (wr_en)
            begin
                valid_reg[slot_reg] <= 1'b1;
                slot_reg            <= slot_next;
                scan_reg            <= 1'b1;
                rd_addr_reg         <= '0;
            end
            else if (scan_reg)
            begin
                if (rd_addr_reg == LAST_ADDR)
                begin
                    scan_reg <= 1'b0;
                end
                else
                begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        daddr_reg <= rd_addr_reg;
        if (wr_en)
        begin
            sum_reg <= '0;
            hi_reg  <= '0;
            lo_reg  <= '1;
        end
        else if (dvld_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(entry);
            if (entry > hi_reg)
            begin
                hi_reg <= entry;
            end
            if (entry < lo_reg)
            begin
                lo_reg <= entry;
            end
        end
        if (fin_reg)
        begin
            trimmed_reg <= sum_reg - SUM_W'(hi_reg) - SUM_W'(lo_reg);
        end
    end

    assign done    = done_reg;
    assign trimmed = trimmed_reg;
endmodule

/* rtl/core/btmm_calc.sv */
// Scaling pipeline: trimmed sum to mean, millivolts and battery level.
module btmm_calc
    import btmm_pkg::*;
#(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(RING_DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] trimmed,
    input  logic [REF_W-1:0] ref_mv,
    input  logic             full,
    output calc_res_t        res
);
    localparam int DIVISOR = RING_DEPTH - 2;
    localparam int DIV_L   = $clog2(DIVISOR);
    localparam int DIV_S   = SUM_W + DIV_L;
    localparam int RECIP   = ((1 << DIV_S) + DIVISOR - 1) / DIVISOR;
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int SCL_W   = SAMPLE_WIDTH + REF_W;
    localparam int T_W     = SCL_W + 4;
    localparam int MV_W    = T_W - SCALE_SHIFT;
    localparam int CMP_W   = (MV_W > VOLT_W) ? MV_W : VOLT_W;
    localparam int Q_W     = STEP_W + DIV5_RECIP_W;

    logic [4:0]              vld_reg;
    logic [SAMPLE_WIDTH-1:0] mean_reg;
    logic [SCL_W-1:0]        scaled_reg;
    logic [VOLT_W-1:0]       volt_reg;
    logic [LEVEL_W-1:0]      base_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [LEVEL_W-1:0]      level_reg;

    logic [PROD_W-1:0]  mean_prod;
    logic [T_W-1:0]     times11;
    logic [CMP_W-1:0]   mv_ext;
    logic [VOLT_W-1:0]  volt_next;
    logic [LEVEL_W-1:0] base_next;
    logic [STEP_W-1:0]  step_next;
    logic [VOLT_W-1:0]  diff_high;
    logic [VOLT_W-1:0]  diff_mid;
    logic [VOLT_W-1:0]  diff_low;
    logic [Q_W-1:0]     q_prod;

    assign mean_prod = PROD_W'(trimmed) * PROD_W'(RECIP_W'(RECIP));
    assign times11   = (T_W'(scaled_reg) << 3) + (T_W'(scaled_reg) << 1) + T_W'(scaled_reg);
    assign mv_ext    = CMP_W'(times11[T_W-1:SCALE_SHIFT]);
    assign volt_next = (mv_ext > CMP_W'(VOLT_MAX)) ? VOLT_MAX : mv_ext[VOLT_W-1:0];

    assign diff_high = volt_reg - LVL_HIGH_MV;
    assign diff_mid  = volt_reg - LVL_MID_MV;
    assign diff_low  = volt_reg - LVL_LOW_MV;

    always_comb
    begin
        base_next = LEVEL_LOW_BASE;
        step_next = '0;
        if (full || (volt_reg > LVL_FULL_MV))
        begin
            base_next = LEVEL_MAX;
        end
        else if (volt_reg > LVL_HIGH_MV)
        begin
            base_next = LEVEL_HIGH_BASE;
            step_next = STEP_W'(diff_high >> HIGH_STEP_SHIFT);
        end
        else if (volt_reg > LVL_MID_MV)
        begin
            base_next = LEVEL_MID_BASE;
            step_next = STEP_W'(diff_mid);
        end
        else if (volt_reg > LVL_LOW_MV)
        begin
            base_next = LEVEL_LOW_BASE;
            step_next = STEP_W'(diff_low >> LOW_STEP_SHIFT);
        end
    end

    assign q_prod = Q_W'(step_reg) * Q_W'(DIV5_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg   <= SAMPLE_WIDTH'(mean_prod >> DIV_S);
        scaled_reg <= SCL_W'(mean_reg) * SCL_W'(ref_mv);
        volt_reg   <= volt_next;
        base_reg   <= base_next;
        step_reg   <= step_next;
        level_reg  <= base_reg + LEVEL_W'(q_prod >> DIV5_SHIFT);
    end

    assign res.done  = vld_reg[4];
    assign res.volt  = volt_reg;
    assign res.level = level_reg;
endmodule

/* rtl/core/btmm_checker.sv */
// Port-level assertions for the battery monitor core, bound to the top level.
module btmm_checker
    import btmm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic               start_conversion,
    input logic [VOLT_W-1:0]  voltage_mv,
    input logic [LEVEL_W-1:0] level_pct,
    input logic               level_changed
);
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(voltage_mv)
            && $stable(level_pct) && $stable(start_conversion) && $stable(level_changed))
        else $error("result transaction changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted back to back");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("result appeared without a busy cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(start_conversion && level_changed) && (level_pct <= LEVEL_MAX))
        else $error("inconsistent result transaction");
endmodule

bind battery_trimmed_mean_monitor_core btmm_checker u_btmm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .start_conversion (result.start_conversion),
    .voltage_mv       (result.voltage_mv),
    .level_pct        (result.level_pct),
    .level_changed    (result.level_changed)
);

/* test/tb_top.sv */
// Self-checking testbench for the battery trimmed-mean monitor core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import btmm_pkg::*;

    localparam int RING_N      = RING_DEPTH_DEF;
    localparam int SMP_W       = SAMPLE_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SHOWN_MAX   = 10;
    localparam int HOLD_CYCLES = 400;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef enum logic
    {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } gauge_op_t;

    typedef enum int
    {
        RX_STEADY,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_RARE_STALL
    } rx_mode_t;

    typedef struct packed {
        logic               start;
        logic [VOLT_W-1:0]  volt;
        logic [LEVEL_W-1:0] level;
        logic               changed;
    } reading_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    btmm_item_if #(.SAMPLE_WIDTH(SMP_W)) item_ch ();
    btmm_result_if                       result_ch ();

    battery_trimmed_mean_monitor_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    logic [SMP_W-1:0]    gm_ring [RING_N];
    int unsigned         gm_slot;
    logic [VOLT_W-1:0]   gm_volt;
    logic [LEVEL_W-1:0]  gm_level;
    logic [PERIOD_W-1:0] gm_ticks;
    logic                gm_slow;
    logic [REF_W-1:0]    gm_ref_mv;
    logic [PERIOD_W-1:0] gm_fast_period;
    logic [PERIOD_W-1:0] gm_slow_period;

    reading_t readings_due [$];

    int n_ticks      = 0;
    int n_samples    = 0;
    int n_full       = 0;
    int n_starts     = 0;
    int n_changes    = 0;
    int n_results    = 0;
    int n_writes     = 0;
    int n_mismatch   = 0;
    int n_unexpected = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    bit gaps_on      = 1'b0;
    bit hold_request = 1'b0;

    always #1 clk = ~clk;

    function automatic void gauge_reset();
        foreach (gm_ring[i])
            gm_ring[i] = '0;
        gm_slot        = 0;
        gm_volt        = '0;
        gm_level       = '0;
        gm_ticks       = '0;
        gm_slow        = 1'b0;
        gm_ref_mv      = 12'd1200;
        gm_fast_period = 8'd1;
        gm_slow_period = 8'd10;
    endfunction

    function automatic logic [LEVEL_W-1:0] level_of(int unsigned mv, logic full);
        if (full || mv > 4200)
            return LEVEL_MAX;
        if (mv > 4000)
            return LEVEL_W'(90 + (mv - 4000) / 20);
        if (mv > 3600)
            return LEVEL_W'(10 + (mv - 3600) / 5);
        if (mv > 3200)
            return LEVEL_W'((mv - 3200) / 40);
        return '0;
    endfunction

    function automatic reading_t gauge_step(gauge_op_t op, logic [SMP_W-1:0] smp, logic full);
        reading_t            r;
        logic [PERIOD_W-1:0] period;
        int unsigned         sum;
        int unsigned         hi;
        int unsigned         lo;
        int unsigned         val;
        int unsigned         mv;
        logic [LEVEL_W-1:0]  lvl;
        r = '0;
        if (op == OP_TICK)
        begin
            period   = gm_slow ? gm_slow_period : gm_fast_period;
            gm_ticks = gm_ticks + 1'b1;
            if (gm_ticks >= period)
            begin
                gm_ticks = '0;
                r.start  = 1'b1;
            end
        end
        else
        begin
            gm_ring[gm_slot] = smp;
            gm_slot = (gm_slot + 1 >= RING_N) ? 0 : gm_slot + 1;
            sum = 0;
            hi  = 0;
            lo  = 32'hFFFF;
            foreach (gm_ring[i])
            begin
                val = 32'(gm_ring[i]);
                sum += val;
                if (val > hi)
                    hi = val;
                if (val < lo)
                    lo = val;
            end
            mv = ((sum - hi - lo) / (RING_N - 2) * gm_ref_mv * 11) >> SCALE_SHIFT;
            if (mv > VOLT_MAX)
                mv = 32'(VOLT_MAX);
            if (gm_volt == mv && gm_volt != 0)
                gm_slow = 1'b1;
            gm_volt = mv[VOLT_W-1:0];
            lvl = level_of(mv, full);
            if (lvl != gm_level)
            begin
                gm_level  = lvl;
                r.changed = 1'b1;
            end
        end
        r.volt  = gm_volt;
        r.level = gm_level;
        return r;
    endfunction

    task automatic send_item(gauge_op_t op, logic [SMP_W-1:0] smp, logic full);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 20) : 0;
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item_ch.valid       <= 1'b1;
        item_ch.operation   <= op;
        item_ch.sample      <= smp;
        item_ch.charge_full <= full;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        readings_due.push_back(gauge_step(op, smp, full));
        if (op == OP_TICK)
            n_ticks++;
        else
        begin
            n_samples++;
            n_full += int'(full);
        end
        @(negedge clk);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_REFERENCE_MV: gm_ref_mv      = val[REF_W-1:0];
            CFG_FAST_PERIOD:  gm_fast_period = val[PERIOD_W-1:0];
            CFG_SLOW_PERIOD:  gm_slow_period = val[PERIOD_W-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic send_noise_run(int unsigned n_items, int unsigned tick_pct);
        gauge_op_t op;
        gaps_on = 1'($urandom_range(0, 1));
        repeat (n_items)
        begin
            op = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_SAMPLE;
            send_item(op, SMP_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_battery_run(int unsigned n_items);
        int unsigned target_mv;
        int          center;
        int          spread;
        int          smp;
        target_mv = $urandom_range(3000, 4500);
        if (gm_ref_mv == 0)
            center = $urandom_range(0, 1023);
        else
            center = target_mv * 2048 / (gm_ref_mv * 11);
        if (center > 1023)
            center = 1023;
        spread  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        gaps_on = $urandom_range(0, 3) != 0;
        repeat (n_items)
        begin
            if ($urandom_range(0, 9) < 4)
                send_item(OP_TICK, SMP_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
            else
            begin
                smp = center + int'($urandom_range(0, 2 * spread)) - spread;
                if (smp < 0)
                    smp = 0;
                if (smp > 1023)
                    smp = 1023;
                send_item(OP_SAMPLE, SMP_W'(smp), $urandom_range(0, 9) == 0);
                center = center + int'($urandom_range(0, 4)) - 2;
            end
        end
    endtask

    task automatic test_tick_divider();
        gaps_on = 1'b0;
        repeat (3) send_item(OP_TICK, '0, 1'b0);
        write_reg(CFG_FAST_PERIOD, 12'd0);
        repeat (2) send_item(OP_TICK, '1, 1'b1);
        write_reg(CFG_SPARE_INDEX, 12'hFFF);
        write_reg(CFG_FAST_PERIOD, 12'd3);
        repeat (4) send_item(OP_TICK, '0, 1'b0);
    endtask

    task automatic test_sample_extremes();
        write_reg(CFG_REFERENCE_MV, 12'd3600);
        send_item(OP_SAMPLE, '1, 1'b0);
        send_item(OP_SAMPLE, '0, 1'b1);
        send_item(OP_SAMPLE, '1, 1'b1);
        send_item(OP_SAMPLE, '1, 1'b0);
        send_item(OP_SAMPLE, '1, 1'b0);
        write_reg(CFG_REFERENCE_MV, 12'd0);
        send_item(OP_SAMPLE, 10'd512, 1'b0);
        send_item(OP_SAMPLE, 10'd512, 1'b1);
    endtask

    // keep the reference at zero so the voltage stays zero, never counts as settled, and the fast period stays active
    task automatic test_fast_divider();
        write_reg(CFG_FAST_PERIOD, 12'd255);
        send_noise_run(280, 95);
        write_reg(CFG_FAST_PERIOD, CFG_DATA_W'($urandom_range(2, 20)));
        send_noise_run(70, 80);
    endtask

    task automatic test_stable_voltage();
        write_reg(CFG_REFERENCE_MV, 12'd1200);
        write_reg(CFG_SLOW_PERIOD, 12'd2);
        gaps_on = 1'b1;
        repeat (8) send_item(OP_SAMPLE, 10'd600, 1'b0);
        repeat (3) send_item(OP_TICK, '0, 1'b0);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_REFERENCE_MV, 12'd3600);
                    write_reg(CFG_SLOW_PERIOD, 12'd1);
                end
                1:
                begin
                    write_reg(CFG_REFERENCE_MV, 12'd1);
                    write_reg(CFG_SLOW_PERIOD, 12'd255);
                end
                2:
                begin
                    write_reg(CFG_REFERENCE_MV, 12'd1200);
                    write_reg(CFG_SLOW_PERIOD, 12'd0);
                end
                default:
                begin
                    write_reg(CFG_REFERENCE_MV, CFG_DATA_W'($urandom_range(600, 3600)));
                    write_reg(CFG_SLOW_PERIOD, CFG_DATA_W'($urandom_range(1, 30)));
                    write_reg(CFG_FAST_PERIOD, CFG_DATA_W'($urandom_range(1, 255)));
                end
            endcase
            repeat (9)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_noise_run($urandom_range(4, 15), 50);
                else
                    send_battery_run($urandom_range(6, 20));
            end
        end
    endtask

    task automatic test_output_backpressure();
        write_reg(CFG_REFERENCE_MV, 12'd2400);
        hold_request = 1'b1;
        gaps_on      = 1'b0;
        repeat (40)
        begin
            if ($urandom_range(0, 1))
                send_item(OP_SAMPLE, SMP_W'($urandom_range(350, 450)),
                          1'($urandom_range(0, 1)));
            else
                send_item(OP_TICK, SMP_W'($urandom_range(0, 1023)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            n_mismatch++;
            if (n_mismatch <= SHOWN_MAX)
                $display("result %0d: %s expected %0d, got %0d", n_results, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_checker
        reading_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            n_results++;
            if (readings_due.size() == 0)
            begin
                n_unexpected++;
                if (n_unexpected <= SHOWN_MAX)
                    $display("result %0d arrived with no transaction pending", n_results);
            end
            else
            begin
                want = readings_due.pop_front();
                check_field("start_conversion", 16'(want.start),
                            16'(result_ch.start_conversion));
                check_field("voltage_mv", 16'(want.volt), 16'(result_ch.voltage_mv));
                check_field("level_pct", 16'(want.level), 16'(result_ch.level_pct));
                check_field("level_changed", 16'(want.changed), 16'(result_ch.level_changed));
                n_starts  += int'(want.start);
                n_changes += int'(want.changed);
            end
        end
    end

    initial
    begin : result_receiver
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        mode      = RX_STEADY;
        mode_left = 0;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    RX_STEADY:       result_ch.ready <= 1'b1;
                    RX_COIN:         result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_EVERY_FOURTH: result_ch.ready <= (mode_left % 4 == 0);
                    default:         result_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("battery_trimmed_mean_monitor_core verification failed");
            $finish;
        end
    end

    initial
    begin
        int errors;
        item_ch.valid       = 1'b0;
        item_ch.operation   = OP_TICK;
        item_ch.sample      = '0;
        item_ch.charge_full = 1'b0;
        gauge_reset();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_tick_divider();
        test_sample_extremes();
        test_fast_divider();
        test_stable_voltage();
        test_random_traffic();
        test_output_backpressure();

        drain();
        repeat (40) @(posedge clk);

        $display("Covered %0d ticks with %0d conversion requests and %0d samples",
                 n_ticks, n_starts, n_samples);
        $display("with %0d level changes and %0d charge-full flags over %0d register writes.",
                 n_changes, n_full, n_writes);
        errors = n_mismatch + n_unexpected + readings_due.size();
        if (errors == 0)
            $display("battery_trimmed_mean_monitor_core verification clean");
        else
            $display("battery_trimmed_mean_monitor_core verification failed");
        $finish;
    end
endmodule
